// ----- hdl/acls_pkg.sv -----
// Package for the autocorrelation lag search block.
// Holds the default sizes, the register map and the sequencer state type.
// No dependencies.
`default_nettype none
package acls_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration register map (index = byte address / 4)
    localparam int        TGT_BITS      = 16;
    localparam logic      REG_TARGET    = 1'b0;
    localparam logic [15:0] TARGET_RESET = 16'sd328;

    // Q1.15 scale of the target
    localparam int        TGT_FRAC      = 15;
    localparam int        FIRST_LAG     = 2;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_RUN   = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_G0T   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/autocorrelation_lag_search.sv -----
// Autocorrelation lag search: top level, sample store, product pipeline and sequencer.
// Depends on acls_pkg.
//
// Sequence: samples load one per cycle while the input is ready. After the closing sample
//   the search forms G0 from n products and a drain, passes one set-up state, then per lag h
//   runs n-h products, a drain, 2 x 30 multiply steps at default sizes, a compare; then hand-over.
// Throughput: one segment at a time; input is not ready during the search.
// Reset: synchronous, active low; clears the counters, sequencer and output valid.
//   The threshold register resets to 328. The sample store is not cleared.
`default_nettype none
module autocorrelation_lag_search #(
    parameter int MAX_SAMPLES = acls_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = acls_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // sample channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  wire logic                                 i_last,
    // result channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]          o_lag,
    output logic                                      o_reached_end,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int NW   = $clog2(MAX_SAMPLES + 1);        // count / lag width
    localparam int IW   = $clog2(MAX_SAMPLES);            // store index width
    localparam int SW   = SAMPLE_BITS + NW;               // running sum width
    localparam int YW   = SAMPLE_BITS + NW + 1;           // centred value width
    localparam int PW   = 2 * YW;                         // product width
    localparam int ACW  = PW + NW;                        // accumulator width
    localparam int TW   = acls_pkg::TGT_BITS;
    localparam int LW   = ACW + NW + 1;                   // acc * n
    localparam int CW   = LW + acls_pkg::TGT_FRAC + 1;    // compare width
    localparam int MW   = TW + NW + 1;                    // shift-add multiplier bits
    localparam int MCW  = $clog2(MW);                     // multiply step count width

    // ---------------- configuration ----------------
    logic signed [TW-1:0] r_target;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= acls_pkg::TARGET_RESET;
        end else if (cfg_wr && paddr[2] == acls_pkg::REG_TARGET) begin
            r_target <= pwdata[TW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == acls_pkg::REG_TARGET) begin
            prdata = {{(32-TW){1'b0}}, r_target};
        end
    end

    // ---------------- control registers ----------------
    acls_pkg::t_state r_state;
    logic [NW-1:0]        r_cnt;
    logic signed [SW-1:0] r_sum;
    logic [NW-1:0]        r_k;
    logic [NW-1:0]        r_h;
    logic                 r_g0_phase;
    logic                 r_v1, r_v2, r_v3;
    logic [NW-1:0]        r_res_lag;
    logic                 r_res_end;

    // payload registers
    logic signed [SAMPLE_BITS-1:0] r_rd_a, r_rd_b;
    logic signed [YW-1:0]          r_ya, r_yb;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACW-1:0]         r_acc;
    logic signed [ACW-1:0]         r_g0;
    logic signed [LW-1:0]          r_lhs;
    logic signed [CW-1:0]          r_rhs;

    // shared multiplier registers
    logic signed [CW-1:0]          r_mc;
    logic signed [CW-1:0]          r_mp;
    logic [MW-1:0]                 r_mq;
    logic [MCW-1:0]                r_mstep;
    logic                          r_msel;

    logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

    logic                 in_acc;
    logic                 issue;
    logic [NW-1:0]        lim;
    logic [NW-1:0]        addr_a;
    logic                 gt;
    logic [NW-1:0]        h_next;
    logic                 mlast;
    logic signed [CW-1:0] mp_add;
    logic signed [MW-1:0] tgt_lim;
    logic                 res_load;

    assign o_in_ready = (r_state == acls_pkg::S_LOAD);
    assign in_acc     = i_in_valid & o_in_ready;
    assign lim        = r_cnt - r_h;
    assign issue      = (r_state == acls_pkg::S_RUN);
    assign addr_a     = r_k + r_h;
    assign gt         = CW'($signed({r_lhs, {acls_pkg::TGT_FRAC{1'b0}}})) > r_rhs;
    assign h_next     = r_h + NW'(1);
    assign mlast      = (r_mstep == MCW'(MW - 1));
    assign tgt_lim    = MW'(r_target) * MW'($signed({1'b0, lim}));
    assign res_load   = (r_state == acls_pkg::S_DONE) && (!o_out_valid || i_out_ready);

    // top multiplier bit carries negative weight
    assign mp_add = !r_mq[0] ? r_mp : (mlast ? r_mp - r_mc : r_mp + r_mc);

    // sample store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (in_acc && r_cnt < NW'(MAX_SAMPLES)) begin
            mem[r_cnt[IW-1:0]] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= mem[addr_a[IW-1:0]];
        r_rd_b <= mem[r_k[IW-1:0]];
    end

    // product pipeline: centre, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_ya   <= YW'($signed({1'b0, r_cnt})) * YW'(r_rd_a) - YW'(r_sum);
        r_yb   <= YW'($signed({1'b0, r_cnt})) * YW'(r_rd_b) - YW'(r_sum);
        r_prod <= r_ya * r_yb;
        if (issue && r_k == '0) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + ACW'(r_prod);
        end
    end

    // shared shift-add multiplier: Gh * n, then G0 * (T * (n-h))
    always_ff @(posedge i_clk) begin
        if (r_state == acls_pkg::S_DRAIN) begin
            r_mc    <= CW'(r_acc);
            r_mq    <= MW'(r_cnt);
            r_mp    <= '0;
            r_mstep <= '0;
            r_msel  <= 1'b0;
            if (r_g0_phase) begin
                r_g0 <= r_acc;
            end
        end else if (r_state == acls_pkg::S_MUL) begin
            if (!mlast) begin
                r_mp    <= mp_add;
                r_mc    <= r_mc <<< 1;
                r_mq    <= r_mq >> 1;
                r_mstep <= r_mstep + MCW'(1);
            end else if (!r_msel) begin
                r_lhs   <= mp_add[LW-1:0];
                r_mc    <= CW'(r_g0);
                r_mq    <= tgt_lim;
                r_mp    <= '0;
                r_mstep <= '0;
                r_msel  <= 1'b1;
            end else begin
                r_rhs <= mp_add;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acls_pkg::S_LOAD;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_k         <= '0;
            r_h         <= '0;
            r_g0_phase  <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_res_lag   <= '0;
            r_res_end   <= 1'b0;
            o_out_valid <= 1'b0;
            o_lag       <= '0;
            o_reached_end <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            // output register: load a new result or clear on acceptance
            if (res_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                acls_pkg::S_LOAD: begin
                    if (in_acc) begin
                        if (r_cnt < NW'(MAX_SAMPLES)) begin
                            r_cnt <= r_cnt + NW'(1);
                            r_sum <= r_sum + SW'(i_sample);
                        end
                        if (i_last) begin
                            r_k        <= '0;
                            r_h        <= '0;
                            r_g0_phase <= 1'b1;
                            r_state    <= acls_pkg::S_RUN;
                        end
                    end
                end
                acls_pkg::S_RUN: begin
                    r_k <= r_k + NW'(1);
                    if (r_k == lim - NW'(1)) begin
                        r_state <= acls_pkg::S_DRAIN;
                    end
                end
                acls_pkg::S_DRAIN: begin
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        if (!r_g0_phase) begin
                            r_state <= acls_pkg::S_MUL;
                        end else if (!r_acc[ACW-1] && r_acc != '0) begin
                            r_state <= acls_pkg::S_G0T;
                        end else begin
                            r_res_lag <= NW'(acls_pkg::FIRST_LAG);
                            r_res_end <= 1'b0;
                            r_state   <= acls_pkg::S_DONE;
                        end
                    end
                end
                acls_pkg::S_G0T: begin
                    r_g0_phase <= 1'b0;
                    r_h        <= NW'(acls_pkg::FIRST_LAG);
                    r_k        <= '0;
                    if (NW'(acls_pkg::FIRST_LAG) >= r_cnt) begin
                        r_res_lag <= r_cnt;
                        r_res_end <= 1'b1;
                        r_state   <= acls_pkg::S_DONE;
                    end else begin
                        r_state <= acls_pkg::S_RUN;
                    end
                end
                acls_pkg::S_MUL: begin
                    if (mlast && r_msel) begin
                        r_state <= acls_pkg::S_CMP;
                    end
                end
                acls_pkg::S_CMP: begin
                    r_k <= '0;
                    if (!gt) begin
                        r_res_lag <= r_h;
                        r_res_end <= 1'b0;
                        r_state   <= acls_pkg::S_DONE;
                    end else if (h_next >= r_cnt) begin
                        r_res_lag <= r_cnt;
                        r_res_end <= 1'b1;
                        r_state   <= acls_pkg::S_DONE;
                    end else begin
                        r_h     <= h_next;
                        r_state <= acls_pkg::S_RUN;
                    end
                end
                acls_pkg::S_DONE: begin
                    // hand the result over once the output register is free
                    if (res_load) begin
                        o_lag         <= r_res_lag;
                        o_reached_end <= r_res_end;
                        r_cnt         <= '0;
                        r_sum         <= '0;
                        r_state       <= acls_pkg::S_LOAD;
                    end
                end
                default: begin
                    r_state <= acls_pkg::S_LOAD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for autocorrelation_lag_search: sample segments in, lag results out.
// Holds its own lag predictor inside a small scoreboard class.
// Depends on acls_pkg and autocorrelation_lag_search.
`timescale 1ns / 100ps
module tb_top;

    localparam int STORE_DEPTH = acls_pkg::MAX_SAMPLES_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [2:0] ADDR_TARGET = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef enum int {SEG_NOISE, SEG_WALK, SEG_RAMP, SEG_FLAT, SEG_EDGES} t_seg_kind;

    typedef struct {
        bit [12:0] lag;
        bit        reached_end;
    } t_lag_result;

    // Lag predictor plus the queue of expected results
    class t_lag_scoreboard;
        logic signed [15:0] samples[STORE_DEPTH];
        int                 count;
        longint             sum;
        int                 target;
        t_lag_result        expected_q[$];
        int                 failures;

        function new();
            count = 0;
            sum = 0;
            target = 328;
            failures = 0;
        endfunction

        function void set_target(logic [15:0] v);
            target = int'($signed(v));
        endfunction

        // exact integer search on n-scaled centred values
        function t_lag_result search_lag(int n);
            longint                c[];
            logic signed [191:0]   g0, gh, lhs, rhs, nn, hh, tt, scale;
            t_lag_result           r;
            c = new[n];
            g0 = 0;
            nn = n;
            tt = target;
            scale = 32768;
            for (int k = 0; k < n; k++) begin
                c[k] = longint'(n) * longint'(samples[k]) - sum;
                g0 += c[k] * c[k];
            end
            r.lag = 13'd2;
            r.reached_end = 1'b0;
            if (g0 <= 0) return r;
            for (int h = 2; h < n; h++) begin
                gh = 0;
                hh = h;
                for (int k = 0; k + h < n; k++) gh += c[k + h] * c[k];
                lhs = gh * nn * scale;
                rhs = g0 * (nn - hh) * tt;
                if (!(lhs > rhs)) begin
                    r.lag = 13'(h);
                    return r;
                end
            end
            r.lag = 13'(n);
            r.reached_end = 1'b1;
            return r;
        endfunction

        function void note_sample(logic signed [15:0] s, logic last);
            if (count < STORE_DEPTH) begin
                samples[count] = s;
                sum += s;
                count++;
            end
            if (last) begin
                expected_q.push_back(search_lag(count));
                count = 0;
                sum = 0;
            end
        endfunction

        function void check_result(bit [12:0] lag, bit reached_end);
            t_lag_result e;
            if (expected_q.size() == 0) begin
                $error("unexpected result lag=%0d reached_end=%0d", lag, reached_end);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (lag != e.lag) begin
                $error("lag: expected %0d actual %0d", e.lag, lag);
                failures++;
            end
            if (reached_end != e.reached_end) begin
                $error("reached_end: expected %0d actual %0d", e.reached_end, reached_end);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic signed [15:0] i_sample = 0;
    logic               i_last = 0;
    logic               i_out_ready = 0;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [2:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    wire                o_in_ready;
    wire                o_out_valid;
    wire  [12:0]        o_lag;
    wire                o_reached_end;
    wire  [31:0]        prdata;
    wire                pready;

    t_lag_scoreboard board = new();
    int              burst_left = 0;
    int              ready_mode = 0;
    int              mode_left = 0;
    longint          cycles = 0;

    autocorrelation_lag_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_sample(i_sample), .i_last(i_last),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_lag(o_lag), .o_reached_end(o_reached_end),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_lag, o_reached_end);
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(5, 60);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // APB write: setup cycle, then access cycle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_TARGET) board.set_target(data[15:0]);
    endtask

    // Stop sending and let all outstanding results drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // One sample transaction, then at the end of a burst usually a random gap
    task automatic send_sample(input logic signed [15:0] s, input logic last);
        i_in_valid <= 1'b1;
        i_sample <= s;
        i_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(s, last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_segment(input int n, input t_seg_kind kind);
        logic signed [15:0] v;
        int                 step;
        v = 16'($urandom);
        step = $urandom_range(1, 300);
        for (int k = 0; k < n; k++) begin
            case (kind)
                SEG_NOISE: v = 16'($urandom);
                SEG_WALK:  v = v + $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
                SEG_RAMP:  v = -16'sd20000 + 16'(k * step);
                SEG_FLAT:  ;
                default:   v = k[0] ? 16'sh7fff : 16'sh8000;
            endcase
            send_sample(v, k == n - 1);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single sample, constant, extremes, a short ramp, lag equal to n
        send_segment(1, SEG_NOISE);
        send_segment(5, SEG_FLAT);
        send_segment(4, SEG_EDGES);
        send_segment(2, SEG_NOISE);
        send_segment(6, SEG_RAMP);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        wait_idle();

        // Ignored register index, then target extremes
        reg_write(ADDR_UNUSED, 32'h0000_8000);
        send_segment(8, SEG_RAMP);
        wait_idle();
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: reg_write(ADDR_TARGET, 32'h0000_8000);
                1: reg_write(ADDR_TARGET, 32'h0000_7fff);
                2: reg_write(ADDR_TARGET, 32'h0000_0000);
                3: reg_write(ADDR_TARGET, $urandom);
                default: reg_write(ADDR_TARGET, 32'd328);
            endcase
            // Random segments, mostly short, rarely long
            for (int s = 0; s < 22; s++) begin
                if (s == 11) wait_idle();
                if ($urandom_range(0, 40) == 0)
                    send_segment($urandom_range(60, 150), t_seg_kind'($urandom_range(0, 1)));
                else
                    send_segment($urandom_range(1, 6), t_seg_kind'($urandom_range(0, 4)));
            end
            wait_idle();
        end

        wait_idle();
        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
